@@ rtl/core/vgbe_pkg.sv @@
package vgbe_pkg;

    // Column count limit of the default build; the column counter saturates there.
    localparam int unsigned MAX_COLUMNS_DEFAULT = 65545;

    localparam int unsigned FIRST_GENOTYPE_COLUMN = 9;
    localparam int unsigned REF_COLUMN = 3;
    localparam int unsigned ALT_COLUMN = 4;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_ZERO = 8'h30;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_START = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INDIVIDUAL_TOTAL = 2'd2;

    localparam logic [15:0] WINDOW_START_RESET = 16'd0;
    localparam logic [15:0] WINDOW_SIZE_RESET = 16'd10;
    localparam logic [15:0] INDIVIDUAL_TOTAL_RESET = 16'd65535;

    // Field position saturates here: three characters seen.
    localparam logic [1:0] FIELD_POS_FULL = 2'd3;
    localparam logic [1:0] FIELD_POS_ONE = 2'd1;
    localparam logic [1:0] FIELD_POS_TWO = 2'd2;

    typedef struct packed {
        logic [15:0] window_start;
        logic [15:0] window_size;
        logic [15:0] individual_total;
    } cfg_t;

    typedef struct packed {
        logic [15:0] individual_offset;
        logic first_haplotype;
        logic second_haplotype;
        logic malformed;
        logic line_end;
    } result_t;

endpackage

@@ rtl/core/vcf_genotype_bit_extractor_unit.sv @@
// VCF genotype bit extractor.
// The slave stream takes VCF text, one byte per transaction in s_tdata. Header
// lines starting with '#' and empty lines are skipped; data lines whose REF or
// ALT column is not exactly one character are dropped. For every genotype
// column whose individual falls in the configured window, one master
// transaction carries the individual's offset in the window and two haplotype
// bits. m_tuser flags a genotype field shorter than three characters (bits then
// zero); m_tlast marks a field closed by a newline.
// The configuration channel writes window_start (0), window_size (1) and
// individual_total (2); indexes beyond that are ignored. It is always ready.
// Throughput is one byte per cycle unless a result waits with m_tready low. A
// byte is held in the input register and then decoded into the result register,
// from which its result is offered on the master stream. The longest path per byte
// is the window test: two 17-bit subtractions and the compares behind them.
// Reset returns the registers to 0, 10 and 65535 and puts the parser at the
// start of a line. When a result waits with m_tready low, the result register
// holds, at most one more byte is taken into the input register, and then
// s_tready drops.
module vcf_genotype_bit_extractor_unit #(
    parameter int unsigned MAX_COLUMNS = vgbe_pkg::MAX_COLUMNS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] text_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [15:0] individual_offset, [16] first_haplotype,
                                     // [17] second_haplotype, [23:18] zero
    output logic        m_tuser,     // [0] malformed
    output logic        m_tlast,     // line_end

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vgbe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data
);

    vgbe_pkg::cfg_t    cfg_reg;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    vgbe_pkg::result_t out_reg;
    logic              proc_fire;
    logic              res_valid;
    vgbe_pkg::result_t res;

    assign cfg_ready = 1'b1;
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_start <= vgbe_pkg::WINDOW_START_RESET;
            cfg_reg.window_size <= vgbe_pkg::WINDOW_SIZE_RESET;
            cfg_reg.individual_total <= vgbe_pkg::INDIVIDUAL_TOTAL_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                vgbe_pkg::REG_WINDOW_START:     cfg_reg.window_start <= cfg_data;
                vgbe_pkg::REG_WINDOW_SIZE:      cfg_reg.window_size <= cfg_data;
                vgbe_pkg::REG_INDIVIDUAL_TOTAL: cfg_reg.individual_total <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    vgbe_field_parser #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_valid(proc_fire),
        .text_byte (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'd0, out_reg.second_haplotype, out_reg.first_haplotype,
                      out_reg.individual_offset};
    assign m_tuser = out_reg.malformed;
    assign m_tlast = out_reg.line_end;

`ifndef SYNTHESIS
    a_byte_held_until_decoded: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !proc_fire) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("buffered text byte lost before decode");

    a_no_decode_into_stalled_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !proc_fire)
        else $error("decode overwrote a pending result");

    a_result_from_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(proc_fire && res_valid))
        else $error("result appeared without a decoded byte");
`endif

endmodule

@@ rtl/core/vgbe_field_parser.sv @@
module vgbe_field_parser #(
    parameter int unsigned MAX_COLUMNS = vgbe_pkg::MAX_COLUMNS_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            byte_valid,
    input  logic [7:0]      text_byte,
    input  vgbe_pkg::cfg_t  cfg,
    output logic            res_valid,
    output vgbe_pkg::result_t res
);

    localparam int unsigned CW = $clog2(MAX_COLUMNS + 1);
    localparam int unsigned IW = (CW > 16) ? CW : 16;

    typedef logic [CW-1:0] col_t;
    typedef logic [IW-1:0] idx_t;

    logic       at_line_start_reg, at_line_start_next;
    logic       skip_line_reg, skip_line_next;
    col_t       column_reg, column_next;
    logic [1:0] field_pos_reg, field_pos_next;
    logic       first_bit_reg, first_bit_next;
    logic       second_bit_reg, second_bit_next;

    logic       is_nl;
    logic       is_sep;
    logic       is_hash;
    logic       eff_skip;
    col_t       eff_col;
    logic [1:0] eff_pos;
    logic       eff_first;
    logic       eff_second;
    logic       refalt_bad;
    logic       genotype_col;
    idx_t       idx;
    idx_t       offset;
    logic       in_window;

    assign is_nl = (text_byte == vgbe_pkg::CH_NEWLINE);
    assign is_sep = is_nl || (text_byte == vgbe_pkg::CH_TAB);
    assign is_hash = (text_byte == vgbe_pkg::CH_HASH);

    // The first byte of a line sees a freshly cleared line state.
    assign eff_skip = at_line_start_reg ? 1'b0 : skip_line_reg;
    assign eff_col = at_line_start_reg ? '0 : column_reg;
    assign eff_pos = at_line_start_reg ? 2'd0 : field_pos_reg;
    assign eff_first = at_line_start_reg ? 1'b0 : first_bit_reg;
    assign eff_second = at_line_start_reg ? 1'b0 : second_bit_reg;

    assign refalt_bad = ((eff_col == CW'(vgbe_pkg::REF_COLUMN)) ||
                         (eff_col == CW'(vgbe_pkg::ALT_COLUMN))) &&
                        (eff_pos != vgbe_pkg::FIELD_POS_ONE);
    assign genotype_col = (eff_col >= CW'(vgbe_pkg::FIRST_GENOTYPE_COLUMN));
    assign idx = idx_t'(eff_col) - idx_t'(vgbe_pkg::FIRST_GENOTYPE_COLUMN);
    assign offset = idx - idx_t'(cfg.window_start);
    assign in_window = (idx >= idx_t'(cfg.window_start)) &&
                       (idx < idx_t'(cfg.individual_total)) &&
                       (offset < idx_t'(cfg.window_size));

    always_comb begin
        res.individual_offset = offset[15:0];
        res.malformed = (eff_pos != vgbe_pkg::FIELD_POS_FULL);
        res.first_haplotype = (eff_pos == vgbe_pkg::FIELD_POS_FULL) && eff_first;
        res.second_haplotype = (eff_pos == vgbe_pkg::FIELD_POS_FULL) && eff_second;
        res.line_end = is_nl;
    end

    always_comb begin
        at_line_start_next = at_line_start_reg;
        skip_line_next = skip_line_reg;
        column_next = column_reg;
        field_pos_next = field_pos_reg;
        first_bit_next = first_bit_reg;
        second_bit_next = second_bit_reg;
        res_valid = 1'b0;
        if (byte_valid && !(at_line_start_reg && is_nl)) begin
            at_line_start_next = 1'b0;
            skip_line_next = eff_skip;
            column_next = eff_col;
            field_pos_next = eff_pos;
            first_bit_next = eff_first;
            second_bit_next = eff_second;
            if (at_line_start_reg && is_hash) begin
                skip_line_next = 1'b1;
            end else if (eff_skip) begin
                if (is_nl) begin
                    at_line_start_next = 1'b1;
                    skip_line_next = 1'b0;
                end
            end else if (!is_sep) begin
                if (eff_pos == 2'd0) begin
                    first_bit_next = (text_byte != vgbe_pkg::CH_ZERO);
                end else if (eff_pos == vgbe_pkg::FIELD_POS_TWO) begin
                    second_bit_next = (text_byte != vgbe_pkg::CH_ZERO);
                end
                if (eff_pos != vgbe_pkg::FIELD_POS_FULL) begin
                    field_pos_next = eff_pos + 2'd1;
                end
            end else begin
                if (refalt_bad) begin
                    skip_line_next = 1'b1;
                end else if (genotype_col && in_window) begin
                    res_valid = 1'b1;
                end
                field_pos_next = 2'd0;
                first_bit_next = 1'b0;
                second_bit_next = 1'b0;
                if (is_nl) begin
                    at_line_start_next = 1'b1;
                    skip_line_next = 1'b0;
                    column_next = '0;
                end else if (eff_col < CW'(MAX_COLUMNS)) begin
                    column_next = eff_col + col_t'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_line_start_reg <= 1'b1;
            skip_line_reg <= 1'b0;
            column_reg <= '0;
            field_pos_reg <= 2'd0;
            first_bit_reg <= 1'b0;
            second_bit_reg <= 1'b0;
        end else begin
            at_line_start_reg <= at_line_start_next;
            skip_line_reg <= skip_line_next;
            column_reg <= column_next;
            field_pos_reg <= field_pos_next;
            first_bit_reg <= first_bit_next;
            second_bit_reg <= second_bit_next;
        end
    end

`ifndef SYNTHESIS
    a_result_only_in_data_line: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (!at_line_start_reg && !skip_line_reg && genotype_col))
        else $error("genotype result raised outside a live data line");

    a_newline_restarts_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_valid && is_nl) |=> (at_line_start_reg && !skip_line_reg))
        else $error("newline did not return to line start");

    a_malformed_clears_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.malformed) |-> (!res.first_haplotype && !res.second_haplotype))
        else $error("malformed genotype carries haplotype bits");

    a_column_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        column_reg <= CW'(MAX_COLUMNS))
        else $error("column counter beyond its limit");
`endif

endmodule

@@ sim/vcf_genotype_bit_extractor_unit_tb.sv @@
module vcf_genotype_bit_extractor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned REPORT_LIMIT = 50;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned LONG_LINE_COLUMNS = 48;
    localparam logic [7:0] CH_ONE = 8'h31;
    localparam logic [7:0] CH_TWO = 8'h32;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PIPE = 8'h7C;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Tracks the parser state and queues the genotype results the block must produce.
    class genotype_scoreboard;
        logic [15:0] win_first;
        logic [15:0] win_len;
        logic [15:0] total_individuals;
        bit line_fresh;
        bit dropping_line;
        int unsigned column_idx;
        int unsigned chars_seen;
        bit allele_a;
        bit allele_b;
        vgbe_pkg::result_t expected_genotypes[$];
        int unsigned errors;

        function new();
            win_first = vgbe_pkg::WINDOW_START_RESET;
            win_len = vgbe_pkg::WINDOW_SIZE_RESET;
            total_individuals = vgbe_pkg::INDIVIDUAL_TOTAL_RESET;
            line_fresh = 1'b1;
            dropping_line = 1'b0;
            column_idx = 0;
            chars_seen = 0;
            allele_a = 1'b0;
            allele_b = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                vgbe_pkg::REG_WINDOW_START: win_first = val;
                vgbe_pkg::REG_WINDOW_SIZE: win_len = val;
                vgbe_pkg::REG_INDIVIDUAL_TOTAL: total_individuals = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_genotypes.size();
        endfunction

        function void note_text_byte(logic [7:0] b);
            bit is_nl;
            bit is_sep;
            bit short_field;
            int unsigned idx;
            vgbe_pkg::result_t r;
            is_nl = (b == vgbe_pkg::CH_NEWLINE);
            is_sep = is_nl || (b == vgbe_pkg::CH_TAB);
            if (line_fresh) begin
                if (is_nl)
                    return;
                line_fresh = 1'b0;
                column_idx = 0;
                chars_seen = 0;
                allele_a = 1'b0;
                allele_b = 1'b0;
                if (b == vgbe_pkg::CH_HASH) begin
                    dropping_line = 1'b1;
                    return;
                end
                dropping_line = 1'b0;
            end
            if (dropping_line) begin
                if (is_nl) begin
                    line_fresh = 1'b1;
                    dropping_line = 1'b0;
                end
                return;
            end
            if (!is_sep) begin
                if (chars_seen == 0)
                    allele_a = (b != vgbe_pkg::CH_ZERO);
                else if (chars_seen == 2)
                    allele_b = (b != vgbe_pkg::CH_ZERO);
                if (chars_seen < 3)
                    chars_seen++;
                return;
            end
            if ((column_idx == vgbe_pkg::REF_COLUMN || column_idx == vgbe_pkg::ALT_COLUMN) &&
                chars_seen != 1) begin
                dropping_line = 1'b1;
            end else if (column_idx >= vgbe_pkg::FIRST_GENOTYPE_COLUMN) begin
                idx = column_idx - vgbe_pkg::FIRST_GENOTYPE_COLUMN;
                if (idx >= win_first && idx < total_individuals &&
                    (idx - win_first) < win_len) begin
                    short_field = (chars_seen < 3);
                    r.individual_offset = 16'(idx - win_first);
                    r.first_haplotype = !short_field && allele_a;
                    r.second_haplotype = !short_field && allele_b;
                    r.malformed = short_field;
                    r.line_end = is_nl;
                    expected_genotypes.insert(expected_genotypes.size(), r);
                end
            end
            chars_seen = 0;
            allele_a = 1'b0;
            allele_b = 1'b0;
            if (is_nl) begin
                line_fresh = 1'b1;
                dropping_line = 1'b0;
                column_idx = 0;
            end else if (column_idx < vgbe_pkg::MAX_COLUMNS_DEFAULT) begin
                column_idx++;
            end
        endfunction

        function void compare_field(string field, logic [15:0] want_v, logic [15:0] got_v);
            if (got_v !== want_v) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $error("%s: expected %0d, got %0d", field, want_v, got_v);
            end
        endfunction

        function void check_genotype(logic [15:0] offset, logic first_h, logic second_h,
                                     logic bad, logic last);
            vgbe_pkg::result_t want;
            if (expected_genotypes.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $error("unexpected result transaction, individual_offset %0d", offset);
                return;
            end
            want = expected_genotypes.pop_front();
            compare_field("individual_offset", want.individual_offset, offset);
            compare_field("first_haplotype", 16'(want.first_haplotype), 16'(first_h));
            compare_field("second_haplotype", 16'(want.second_haplotype), 16'(second_h));
            compare_field("malformed", 16'(want.malformed), 16'(bad));
            compare_field("line_end", 16'(want.line_end), 16'(last));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'h0000;

    genotype_scoreboard sb = new();
    int unsigned bytes_sent = 0;
    int unsigned burst_left = 0;
    int unsigned quiet_cycles = 0;

    vcf_genotype_bit_extractor_unit uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Both streams are sampled at the edge, so the values seen are the ones before it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_genotype(m_tdata[15:0], m_tdata[16], m_tdata[17], m_tuser, m_tlast);
            if (s_tvalid && s_tready)
                sb.note_text_byte(s_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("vcf_genotype_bit_extractor_unit regression: fail");
                $finish;
            end
        end
    end

    // Result side: runs of always-ready, random, mostly-stalled and alternating behavior,
    // plus one long hold that starts while a result is waiting, so the block fills up behind it.
    initial begin
        int mode;
        int span;
        bit held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 96);
            repeat (span) begin
                if (!held && bytes_sent >= 400 && m_tvalid) begin
                    held = 1'b1;
                    m_tready <= 1'b0;
                    repeat (RX_HOLD_CYCLES) @(posedge aclk);
                end
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
                @(posedge aclk);
            end
        end
    end

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == vgbe_pkg::CH_TAB || b == vgbe_pkg::CH_NEWLINE);
        return b;
    endfunction

    function automatic logic [7:0] pick_allele();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return vgbe_pkg::CH_ZERO;
            4: return CH_ONE;
            5: return CH_TWO;
            6: return CH_DOT;
            default: return rand_text_byte();
        endcase
    endfunction

    // The sender keeps tvalid high within a burst and drops it only for a gap.
    task automatic put_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
        burst_left--;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic put_field_text(input int n);
        repeat (n) put_byte(rand_text_byte());
    endtask

    task automatic put_genotype();
        case ($urandom_range(0, 19))
            0: ;
            1: put_byte(pick_allele());
            2: begin
                put_byte(pick_allele());
                put_byte(pick_allele());
            end
            3: put_field_text($urandom_range(4, 7));
            default: begin
                put_byte(pick_allele());
                put_byte($urandom_range(0, 1) ? CH_SLASH : CH_PIPE);
                put_byte(pick_allele());
            end
        endcase
    endtask

    // One record of text: headers, empty lines, noise without a closing newline, short
    // lines, lines with a bad REF or ALT column, and mostly well-formed data lines.
    task automatic put_record(input int max_gt);
        int kind;
        int ncols;
        int bad_col;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            put_byte(vgbe_pkg::CH_HASH);
            repeat ($urandom_range(0, 12))
                put_byte(($urandom_range(0, 4) == 0) ? vgbe_pkg::CH_TAB : rand_text_byte());
            put_byte(vgbe_pkg::CH_NEWLINE);
        end else if (kind < 12) begin
            put_byte(vgbe_pkg::CH_NEWLINE);
        end else if (kind < 18) begin
            repeat ($urandom_range(1, 24))
                put_byte(8'($urandom_range(0, 255)));
        end else begin
            ncols = (kind < 24) ? $urandom_range(1, 9) : vgbe_pkg::FIRST_GENOTYPE_COLUMN;
            bad_col = (kind >= 24 && kind < 32) ?
                      $urandom_range(vgbe_pkg::REF_COLUMN, vgbe_pkg::ALT_COLUMN) : -1;
            for (int i = 0; i < ncols; i++) begin
                if (i > 0)
                    put_byte(vgbe_pkg::CH_TAB);
                if (i == bad_col)
                    put_field_text($urandom_range(0, 1) ? 0 : $urandom_range(2, 3));
                else if (i == vgbe_pkg::REF_COLUMN || i == vgbe_pkg::ALT_COLUMN)
                    put_field_text(1);
                else
                    put_field_text($urandom_range(0, 4));
            end
            if (ncols == vgbe_pkg::FIRST_GENOTYPE_COLUMN) begin
                repeat ($urandom_range(0, max_gt)) begin
                    put_byte(vgbe_pkg::CH_TAB);
                    put_genotype();
                end
            end
            if ($urandom_range(0, 7) == 0)
                put_byte(CH_CR);
            put_byte(vgbe_pkg::CH_NEWLINE);
        end
    endtask

    // Always waits for the clock before returning, so tvalid is never lowered and raised in one step.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic settle();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_window(input logic [15:0] first, input logic [15:0] len,
                                  input logic [15:0] total, input bit poke_unused);
        logic [1:0] idx_q[$];
        logic [15:0] val_q[$];
        idx_q = '{vgbe_pkg::REG_WINDOW_START, vgbe_pkg::REG_WINDOW_SIZE,
                  vgbe_pkg::REG_INDIVIDUAL_TOTAL};
        val_q = '{first, len, total};
        if (poke_unused) begin
            idx_q.push_front(REG_UNUSED);
            val_q.push_front(16'hFFFF);
        end
        foreach (idx_q[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_q[i];
            cfg_data <= val_q[i];
            @(posedge aclk);
            while (!cfg_ready)
                @(posedge aclk);
            sb.write_reg(idx_q[i], val_q[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] first, input logic [15:0] len,
                             input logic [15:0] total, input int budget, input int max_gt);
        int unsigned start_count;
        settle();
        program_window(first, len, total, 1'b0);
        start_count = bytes_sent;
        while (bytes_sent - start_count < budget) begin
            put_record(max_gt);
            if ($urandom_range(0, 24) == 0)
                pause_until_drained();
        end
    endtask

    // A line with many genotype columns under the widest window: every individual
    // on it is emitted, mostly as short fields.
    task automatic put_long_line();
        settle();
        program_window(16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        put_text("1\t2\t3\tA\tC\t5\t6\t7\t8");
        for (int i = 0; i < LONG_LINE_COLUMNS; i++) begin
            put_byte(vgbe_pkg::CH_TAB);
            if ($urandom_range(0, 3) == 0)
                put_genotype();
        end
        put_byte(vgbe_pkg::CH_NEWLINE);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        put_text("#hdr\n\n");
        put_text("\t\t\tA\tG\t\t\t\t1/0\t0|1\t\n");
        put_text("\t\t\tA\tG\t\t\t\t");
        put_byte(8'hFF);
        put_byte(CH_SLASH);
        put_byte(8'h00);
        put_text("\t1/1/1\t0");
        put_byte(CH_CR);
        put_byte(vgbe_pkg::CH_NEWLINE);
        put_text("\t\t\tAC\tG\t\t\t\t1/1\n");
        put_text("a\tb\n");
        put_text("x\t#\t\tA\tT\t\t\t\t0/0\n");

        run_phase(16'd0, 16'd0, 16'hFFFF, 100, 12);
        run_phase(16'd0, 16'hFFFF, 16'd0, 100, 12);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 100, 12);
        repeat (8) begin
            if ($urandom_range(0, 3) == 0)
                run_phase(16'($urandom_range(0, 4)), 16'hFFFF, 16'hFFFF, 140, 14);
            else
                run_phase(16'($urandom_range(0, 4)), 16'($urandom_range(1, 8)),
                          16'($urandom_range(0, 12)), 140, 14);
        end
        put_long_line();
        run_phase(16'd2, 16'd5, 16'd6, 100, 10);
        settle();

        if (sb.errors == 0)
            $display("vcf_genotype_bit_extractor_unit regression: pass");
        else
            $display("vcf_genotype_bit_extractor_unit regression: fail");
        $finish;
    end

endmodule

@@ vcf_genotype_bit_extractor_unit.f @@
rtl/core/vgbe_pkg.sv
rtl/core/vgbe_field_parser.sv
rtl/core/vcf_genotype_bit_extractor_unit.sv
sim/vcf_genotype_bit_extractor_unit_tb.sv
